/* hw/rtl/pulse_train_repeat_capture_unit_macros.svh */
// ----------------------------------------------------------------------------
// Pulse train repeat capture: assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PULSE_TRAIN_REPEAT_CAPTURE_UNIT_MACROS_SVH
`define PULSE_TRAIN_REPEAT_CAPTURE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every edge.
`define PRTC_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("prtc check failed");

// Check that a condition implies another at the same edge.
`define PRTC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prtc check failed");

// Check that a condition implies another at the next edge.
`define PRTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prtc check failed");

`else

`define PRTC_ASSERT_ALWAYS(lbl, cond)
`define PRTC_ASSERT_IMPLY(lbl, ante, cons)
`define PRTC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hw/rtl/prtc_pkg.sv */
// ----------------------------------------------------------------------------
// Pulse train repeat capture: shared package
// Sequencer states, register indexes, match stages and reset values.
// ----------------------------------------------------------------------------
package prtc_pkg;

    localparam int WIDTH_W = 16;
    localparam int POS_W   = 6;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Configuration register indexes
    localparam logic CFG_MATCH_TOL = 1'b0;
    localparam logic CFG_SYNC_THR  = 1'b1;

    localparam logic [WIDTH_W-1:0] TOL_RESET  = 16'd500;
    localparam logic [WIDTH_W-1:0] SYNC_RESET = 16'd5100;

    // Match stage codes
    localparam logic [1:0] STAGE_NONE = 2'd0;
    localparam logic [1:0] STAGE_ONE  = 2'd1;
    localparam logic [1:0] STAGE_MANY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EMIT_RD,
        ST_EMIT_LD
    } prtc_state_t;

endpackage

/* hw/rtl/prtc_store.sv */
// ----------------------------------------------------------------------------
// Pulse train repeat capture: pulse store
// One write and one registered read port; entries read as zero until written.
// ----------------------------------------------------------------------------
module prtc_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [prtc_pkg::WIDTH_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [prtc_pkg::WIDTH_W-1:0] rd_data
);
    import prtc_pkg::*;

    logic [WIDTH_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [WIDTH_W-1:0] rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Unwritten entries hold their reset value of zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* hw/rtl/pulse_train_repeat_capture_unit.sv */
// ----------------------------------------------------------------------------
// Pulse train repeat capture unit
// Flow: a pulse is accepted, then compared and stored in the next cycle;
//   s_tready is high again once ST_CMP returns to ST_IDLE with no train to emit.
// Emission: each word is a store read (ST_EMIT_RD) followed by an output
//   load (ST_EMIT_LD); each read waits for the previous word to load and
//   for the output word slot to free up, so an output stall holds the read.
// Reset: rst_n clears counters, stage and store valid bits at once and loads
//   the tolerance (500) and sync threshold (5100) registers.
// ----------------------------------------------------------------------------
`include "pulse_train_repeat_capture_unit_macros.svh"

module pulse_train_repeat_capture_unit #(
    parameter int TRAIN_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Pulse input. tdata: [15:0] pulse_width. tlast: batch_last.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [prtc_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tlast,
    // Train output. tdata: [15:0] stored_width, [21:16] position, rest zero.
    // tlast: train_last.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [prtc_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [prtc_pkg::WIDTH_W-1:0]     cfg_data
);
    import prtc_pkg::*;

    localparam int AW = $clog2(TRAIN_DEPTH);
    localparam int CW = $clog2(TRAIN_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TRAIN_DEPTH);

    // batch_last has no effect on detection; the tlast bit is accepted and dropped.

    prtc_state_t        state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [1:0]         stage_reg, stage_next;
    logic [WIDTH_W-1:0] tol_reg, thr_reg;
    logic [WIDTH_W-1:0] pulse_reg, pulse_next;
    logic [CW-1:0]      emit_len_reg, emit_len_next;
    logic [CW-1:0]      emit_idx_reg, emit_idx_next;
    logic               m_valid_reg, m_valid_next;
    logic [WIDTH_W-1:0] m_data_reg, m_data_next;
    logic [POS_W-1:0]   m_pos_reg, m_pos_next;
    logic               m_last_reg, m_last_next;

    // Store port signals
    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [WIDTH_W-1:0] rd_data;

    // Compare stage terms
    logic               in_range;
    logic               mismatch;
    logic [WIDTH_W-1:0] diff;
    logic [CW-1:0]      cnt_a, cnt_b;
    logic [1:0]         stage_a;
    logic               sync_hit;
    logic               emit_last;

    logic s_accept;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    prtc_store #(
        .DEPTH (TRAIN_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (pulse_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Configuration registers: write them only while no pulse is in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
            thr_reg <= SYNC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MATCH_TOL: tol_reg <= cfg_data;
                CFG_SYNC_THR:  thr_reg <= cfg_data;
                default:       tol_reg <= tol_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            stage_reg    <= STAGE_NONE;
            emit_len_reg <= '0;
            emit_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            stage_reg    <= stage_next;
            emit_len_reg <= emit_len_next;
            emit_idx_reg <= emit_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        pulse_reg  <= pulse_next;
        m_data_reg <= m_data_next;
        m_pos_reg  <= m_pos_next;
        m_last_reg <= m_last_next;
    end

    // Compare terms: the store word at count_reg is on rd_data in ST_CMP
    always_comb
    begin
        in_range = (count_reg < DEPTH_C);
        diff     = (rd_data > pulse_reg) ? (rd_data - pulse_reg) : (pulse_reg - rd_data);
        mismatch = in_range && (stage_reg != STAGE_NONE) && (diff > tol_reg);
        cnt_a    = mismatch ? '0 : count_reg;
        stage_a  = mismatch ? STAGE_NONE : stage_reg;
        // Saturate the position at depth instead of wrapping
        cnt_b    = (cnt_a < DEPTH_C) ? (cnt_a + CW'(1)) : cnt_a;
        sync_hit = (pulse_reg > thr_reg);
        emit_last = (emit_idx_reg == (emit_len_reg - CW'(1)));
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        stage_next    = stage_reg;
        emit_len_next = emit_len_reg;
        emit_idx_next = emit_idx_reg;
        pulse_next    = pulse_reg;
        m_data_next   = m_data_reg;
        m_pos_next    = m_pos_reg;
        m_last_next   = m_last_reg;
        // Drop the output word once it is taken
        m_valid_next  = m_valid_reg && !m_tready;
        wr_en         = 1'b0;
        wr_addr       = '0;
        rd_en         = 1'b0;
        rd_addr       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    // Capture the pulse and fetch the stored word at its position
                    pulse_next = s_tdata[WIDTH_W-1:0];
                    rd_en      = in_range;
                    rd_addr    = in_range ? count_reg[AW-1:0] : '0;
                    state_next = ST_CMP;
                end
            end

            ST_CMP:
            begin
                // Store while no train is held; restart the store on a mismatch
                wr_en   = in_range && ((stage_reg == STAGE_NONE) || mismatch);
                wr_addr = mismatch ? '0 : count_reg[AW-1:0];
                if (sync_hit)
                begin
                    count_next = '0;
                    stage_next = (stage_a < STAGE_MANY) ? (stage_a + 2'd1) : stage_a;
                    if (stage_a == STAGE_ONE)
                    begin
                        emit_len_next = cnt_b;
                        emit_idx_next = '0;
                        state_next    = ST_EMIT_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    count_next = cnt_b;
                    stage_next = stage_a;
                    state_next = ST_IDLE;
                end
            end

            ST_EMIT_RD:
            begin
                // Issue the read only once the output word slot frees up
                if (!m_valid_reg || m_tready)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = emit_idx_reg[AW-1:0];
                    state_next = ST_EMIT_LD;
                end
            end

            ST_EMIT_LD:
            begin
                m_valid_next = 1'b1;
                m_data_next  = rd_data;
                m_pos_next   = POS_W'(emit_idx_reg);
                m_last_next  = emit_last;
                if (emit_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    emit_idx_next = emit_idx_reg + CW'(1);
                    state_next    = ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(OUT_TDATA_W - WIDTH_W - POS_W){1'b0}}, m_pos_reg, m_data_reg};

    `PRTC_ASSERT_ALWAYS(a_count_bounded, count_reg <= DEPTH_C)
    `PRTC_ASSERT_ALWAYS(a_stage_bounded, stage_reg <= STAGE_MANY)
    `PRTC_ASSERT_NEXT(a_accept_to_cmp, s_tvalid && s_tready, state_reg == ST_CMP)
    `PRTC_ASSERT_IMPLY(a_emit_idx_in_run, state_reg == ST_EMIT_RD, emit_idx_reg < emit_len_reg)

endmodule
